// File: hw/rtl/assert_macros.svh
// Assertion macros for the checker file hwq_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property, idle while reset is high
`define HWQ_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("hann window check failed");

// Checked property, also watched during reset
`define HWQ_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("hann window check failed");

`endif

// File: hw/rtl/hwq_pkg.sv
// Shared types, constants and the quarter-sine table of the Hann window unit.
// No dependencies.
package hwq_pkg;

   localparam int unsigned QUARTER_TABLE_ENTRIES = 65;
   localparam logic [15:0] LEN_RESET     = 16'd1024;
   localparam logic [15:0] LEN_MIN       = 16'd3;
   localparam logic [31:0] QUARTER_PHASE = 32'h4000_0000;
   localparam int unsigned DIV_BITS      = 48;
   localparam logic [5:0]  DIV_LAST      = 6'(DIV_BITS - 1);

   // One queued sample with its frame position already classified
   typedef struct packed {
      logic signed [15:0] sample;
      logic [15:0]        mirror_pos;
      logic [15:0]        len;
      logic               last;
   } item_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIVP,
      ST_TAB,
      ST_COEF,
      ST_MUL,
      ST_SQR,
      ST_DIVC,
      ST_WAITC,
      ST_DIVS,
      ST_WAITS,
      ST_OUT
   } state_type;

   function automatic logic [15:0] quarter_sine(input logic [6:0] off);
      logic [15:0] v;
      case (off)
         7'd0: v = 16'd0;      7'd1: v = 16'd804;    7'd2: v = 16'd1608;
         7'd3: v = 16'd2410;   7'd4: v = 16'd3212;   7'd5: v = 16'd4011;
         7'd6: v = 16'd4808;   7'd7: v = 16'd5602;   7'd8: v = 16'd6393;
         7'd9: v = 16'd7179;   7'd10: v = 16'd7962;  7'd11: v = 16'd8739;
         7'd12: v = 16'd9512;  7'd13: v = 16'd10278; 7'd14: v = 16'd11039;
         7'd15: v = 16'd11793; 7'd16: v = 16'd12539; 7'd17: v = 16'd13279;
         7'd18: v = 16'd14010; 7'd19: v = 16'd14732; 7'd20: v = 16'd15446;
         7'd21: v = 16'd16151; 7'd22: v = 16'd16846; 7'd23: v = 16'd17530;
         7'd24: v = 16'd18204; 7'd25: v = 16'd18868; 7'd26: v = 16'd19519;
         7'd27: v = 16'd20159; 7'd28: v = 16'd20787; 7'd29: v = 16'd21403;
         7'd30: v = 16'd22005; 7'd31: v = 16'd22594; 7'd32: v = 16'd23170;
         7'd33: v = 16'd23731; 7'd34: v = 16'd24279; 7'd35: v = 16'd24811;
         7'd36: v = 16'd25329; 7'd37: v = 16'd25832; 7'd38: v = 16'd26319;
         7'd39: v = 16'd26790; 7'd40: v = 16'd27245; 7'd41: v = 16'd27683;
         7'd42: v = 16'd28105; 7'd43: v = 16'd28510; 7'd44: v = 16'd28898;
         7'd45: v = 16'd29268; 7'd46: v = 16'd29621; 7'd47: v = 16'd29956;
         7'd48: v = 16'd30273; 7'd49: v = 16'd30571; 7'd50: v = 16'd30852;
         7'd51: v = 16'd31113; 7'd52: v = 16'd31356; 7'd53: v = 16'd31580;
         7'd54: v = 16'd31785; 7'd55: v = 16'd31971; 7'd56: v = 16'd32137;
         7'd57: v = 16'd32285; 7'd58: v = 16'd32412; 7'd59: v = 16'd32521;
         7'd60: v = 16'd32609; 7'd61: v = 16'd32678; 7'd62: v = 16'd32728;
         7'd63: v = 16'd32757; 7'd64: v = 16'd32767;
         default: v = 16'd0;
      endcase
      return v;
   endfunction

   // Full-circle sine from 256 steps: mirror odd quadrants, negate the lower half
   function automatic logic signed [17:0] table_sine(input logic [7:0] idx);
      logic [6:0]         off;
      logic signed [17:0] mag;
      off = {1'b0, idx[5:0]};
      if (idx[6]) off = 7'd64 - off;
      mag = signed'({2'b00, quarter_sine(off)});
      return idx[7] ? -mag : mag;
   endfunction

endpackage

// File: hw/rtl/hann_window_q15_apply_unit.sv
// Hann window unit in Q15: each req_ beat carries one sample, each rsp_ beat
// returns the windowed sample, its coefficient and, on the last beat of a frame,
// the coherent and power gains of that frame (zero on other beats).
// Depends on hwq_pkg, hwq_front, hwq_queue, hwq_back.
//
// Write the frame length on csr_ while no item is in flight; csr_ready is always
// high and a write restarts the frame. Lengths below 3 act as 3.
// The front takes a sample into a two-entry queue and stalls req_ only when that
// queue is full. The back takes one sample at a time from the queue; its 48-step
// bit-serial divider turns the frame position into a phase, and the last sample
// of a frame adds two more divisions for the two gains. A stalled rsp_ beat holds
// in the output register; the back finishes the next sample and waits, and the
// queue keeps taking samples until it fills.
// Reset (synchronous, active high) empties the queue, drops rsp_valid, sets the
// length to 1024 and starts a fresh frame.
module hann_window_q15_apply_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_sample,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_windowed_sample,
   output logic [14:0]        rsp_coefficient,
   output logic               rsp_last_of_frame,
   output logic [14:0]        rsp_coherent_gain_q15,
   output logic [29:0]        rsp_power_gain_q30,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [15:0]        csr_data
);
   logic              push, pop, q_full, q_not_empty, cfg_clear;
   hwq_pkg::item_type push_item, head;

   hwq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_sample (req_sample),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .queue_full (q_full),
      .push       (push),
      .push_item  (push_item),
      .cfg_clear  (cfg_clear)
   );

   hwq_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (head)
   );

   hwq_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .cfg_clear             (cfg_clear),
      .queue_not_empty       (q_not_empty),
      .head                  (head),
      .pop                   (pop),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_windowed_sample   (rsp_windowed_sample),
      .rsp_coefficient       (rsp_coefficient),
      .rsp_last_of_frame     (rsp_last_of_frame),
      .rsp_coherent_gain_q15 (rsp_coherent_gain_q15),
      .rsp_power_gain_q30    (rsp_power_gain_q30)
   );
endmodule

// File: hw/rtl/hwq_queue.sv
// Two-entry queue between front and back of the Hann window unit.
// Depends on hwq_pkg.
module hwq_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  hwq_pkg::item_type push_item,
   input  logic              pop,
   output logic              full,
   output logic              not_empty,
   output hwq_pkg::item_type head
);
   hwq_pkg::item_type slot_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = slot_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store a beat
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_item;
   end
endmodule

// File: hw/rtl/hwq_front.sv
// Front part: length register, frame position tracking, queue push.
// Depends on hwq_pkg.
module hwq_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic signed [15:0] req_sample,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [15:0]       csr_data,
   input  logic              queue_full,
   output logic              push,
   output hwq_pkg::item_type push_item,
   output logic              cfg_clear
);
   logic [15:0] len_ff, len_in;
   logic [15:0] pos_ff, pos_in;
   logic [15:0] len_eff, len_m1, pos, rev;
   logic        last;

   assign csr_ready = 1'b1;
   assign cfg_clear = csr_valid;
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   // Classify the incoming beat
   always_comb begin
      len_eff = (len_ff < hwq_pkg::LEN_MIN) ? hwq_pkg::LEN_MIN : len_ff;
      len_m1  = len_eff - 16'd1;
      pos     = (pos_ff >= len_eff) ? 16'd0 : pos_ff;
      rev     = len_m1 - pos;
      last    = (pos == len_m1);
      push_item.sample     = req_sample;
      push_item.mirror_pos = (pos < rev) ? pos : rev;
      push_item.len        = len_eff;
      push_item.last       = last;
      len_in = csr_valid ? csr_data : len_ff;
      if (csr_valid) pos_in = 16'd0;
      else if (push) pos_in = last ? 16'd0 : pos + 16'd1;
      else pos_in = pos_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= hwq_pkg::LEN_RESET;
         pos_ff <= 16'd0;
      end else begin
         len_ff <= len_in;
         pos_ff <= pos_in;
      end
   end
endmodule

// File: hw/rtl/hwq_div.sv
// Restoring divider, one quotient bit per cycle, 48-bit dividend, 16-bit divisor.
// Depends on hwq_pkg.
module hwq_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [47:0] dividend,
   input  logic [15:0] divisor,
   output logic        done,
   output logic [47:0] quotient
);
   logic [47:0] quo_ff, quo_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [16:0] shifted, diff;

   assign done     = done_ff;
   assign quotient = quo_ff;

   // Shift in one dividend bit, subtract when it fits
   always_comb begin
      shifted = {rem_ff, quo_ff[47]};
      diff    = shifted - {1'b0, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start && !busy_ff) begin
         quo_in  = dividend;
         rem_in  = 16'd0;
         dvs_in  = divisor;
         cnt_in  = 6'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[16]) begin
            rem_in = diff[15:0];
            quo_in = {quo_ff[46:0], 1'b1};
         end else begin
            rem_in = shifted[15:0];
            quo_in = {quo_ff[46:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == hwq_pkg::DIV_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end
endmodule

// File: hw/rtl/hwq_back.sv
// Back part: phase, interpolated cosine, coefficient, product, frame gains, output.
// Depends on hwq_pkg and hwq_div.
module hwq_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               cfg_clear,
   input  logic               queue_not_empty,
   input  hwq_pkg::item_type  head,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_windowed_sample,
   output logic [14:0]        rsp_coefficient,
   output logic               rsp_last_of_frame,
   output logic [14:0]        rsp_coherent_gain_q15,
   output logic [29:0]        rsp_power_gain_q30
);
   hwq_pkg::state_type state_ff, state_in;
   hwq_pkg::item_type  item_ff, item_in;
   logic [31:0]        phase_ff, phase_in;
   logic signed [17:0] a_ff, a_in;
   logic signed [34:0] ip_ff, ip_in;
   logic [14:0]        coef_ff, coef_in;
   logic signed [31:0] prod_ff, prod_in;
   logic signed [15:0] w_ff, w_in;
   logic [30:0]        ctot_ff, ctot_in;
   logic [46:0]        stot_ff, stot_in;
   logic [14:0]        cg_ff, cg_in;
   logic [29:0]        pg_ff, pg_in;
   logic               valid_ff, valid_in;
   logic signed [15:0] o_w_ff, o_w_in;
   logic [14:0]        o_coef_ff, o_coef_in;
   logic               o_last_ff, o_last_in;
   logic [14:0]        o_cg_ff, o_cg_in;
   logic [29:0]        o_pg_ff, o_pg_in;

   logic        div_start, div_done;
   logic [47:0] div_dividend, div_quotient;
   logic [15:0] div_divisor;

   logic [31:0]        ph;
   logic [7:0]         idx;
   logic signed [17:0] sb;
   logic signed [34:0] ip_abs;
   logic signed [17:0] rnd, cosv, numer;
   logic [31:0]        p_abs;
   logic [16:0]        w_mag;
   logic [29:0]        sq;
   logic [47:0]        half;

   assign rsp_valid             = valid_ff;
   assign rsp_windowed_sample   = o_w_ff;
   assign rsp_coefficient       = o_coef_ff;
   assign rsp_last_of_frame     = o_last_ff;
   assign rsp_coherent_gain_q15 = o_cg_ff;
   assign rsp_power_gain_q30    = o_pg_ff;

   hwq_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Sequence one item through the datapath
   always_comb begin
      state_in  = state_ff;
      item_in   = item_ff;
      phase_in  = phase_ff;
      a_in      = a_ff;
      ip_in     = ip_ff;
      coef_in   = coef_ff;
      prod_in   = prod_ff;
      w_in      = w_ff;
      ctot_in   = ctot_ff;
      stot_in   = stot_ff;
      cg_in     = cg_ff;
      pg_in     = pg_ff;
      valid_in  = valid_ff && rsp_stall;
      o_w_in    = o_w_ff;
      o_coef_in = o_coef_ff;
      o_last_in = o_last_ff;
      o_cg_in   = o_cg_ff;
      o_pg_in   = o_pg_ff;
      pop       = 1'b0;
      div_start = 1'b0;
      half      = 48'(item_ff.len >> 1);
      div_dividend = {head.mirror_pos, 32'h0};
      div_divisor  = head.len - 16'd1;

      ph     = phase_ff + hwq_pkg::QUARTER_PHASE;
      idx    = ph[31:24];
      sb     = hwq_pkg::table_sine(idx + 8'd1);
      ip_abs = ip_ff[34] ? -ip_ff : ip_ff;
      rnd    = 18'((ip_abs + 35'sd32768) >>> 16);
      cosv   = ip_ff[34] ? a_ff - rnd : a_ff + rnd;
      numer  = 18'sd32768 - cosv;
      p_abs  = prod_ff[31] ? 32'(-prod_ff) : 32'(prod_ff);
      w_mag  = 17'((p_abs + 32'd16384) >> 15);
      sq     = {15'd0, coef_ff} * {15'd0, coef_ff};

      case (state_ff)
         hwq_pkg::ST_IDLE: begin
            if (queue_not_empty) begin
               item_in   = head;
               pop       = 1'b1;
               div_start = 1'b1;
               state_in  = hwq_pkg::ST_DIVP;
            end
         end
         hwq_pkg::ST_DIVP: begin
            if (div_done) begin
               phase_in = div_quotient[31:0];
               state_in = hwq_pkg::ST_TAB;
            end
         end
         hwq_pkg::ST_TAB: begin
            a_in     = hwq_pkg::table_sine(idx);
            ip_in    = (sb - hwq_pkg::table_sine(idx)) * signed'({1'b0, ph[23:8]});
            state_in = hwq_pkg::ST_COEF;
         end
         hwq_pkg::ST_COEF: begin
            coef_in  = numer[15:1];
            state_in = hwq_pkg::ST_MUL;
         end
         hwq_pkg::ST_MUL: begin
            prod_in  = item_ff.sample * signed'({1'b0, coef_ff});
            state_in = hwq_pkg::ST_SQR;
         end
         hwq_pkg::ST_SQR: begin
            w_in     = prod_ff[31] ? -16'(w_mag) : 16'(w_mag);
            ctot_in  = ctot_ff + 31'(coef_ff);
            stot_in  = stot_ff + 47'(sq);
            state_in = item_ff.last ? hwq_pkg::ST_DIVC : hwq_pkg::ST_OUT;
         end
         hwq_pkg::ST_DIVC: begin
            div_start    = 1'b1;
            div_dividend = 48'(ctot_ff) + half;
            div_divisor  = item_ff.len;
            state_in     = hwq_pkg::ST_WAITC;
         end
         hwq_pkg::ST_WAITC: begin
            if (div_done) begin
               cg_in    = div_quotient[14:0];
               state_in = hwq_pkg::ST_DIVS;
            end
         end
         hwq_pkg::ST_DIVS: begin
            div_start    = 1'b1;
            div_dividend = 48'(stot_ff) + half;
            div_divisor  = item_ff.len;
            state_in     = hwq_pkg::ST_WAITS;
         end
         hwq_pkg::ST_WAITS: begin
            if (div_done) begin
               pg_in    = div_quotient[29:0];
               ctot_in  = 31'd0;
               stot_in  = 47'd0;
               state_in = hwq_pkg::ST_OUT;
            end
         end
         hwq_pkg::ST_OUT: begin
            if (!valid_ff || !rsp_stall) begin
               valid_in  = 1'b1;
               o_w_in    = w_ff;
               o_coef_in = coef_ff;
               o_last_in = item_ff.last;
               o_cg_in   = item_ff.last ? cg_ff : 15'd0;
               o_pg_in   = item_ff.last ? pg_ff : 30'd0;
               state_in  = hwq_pkg::ST_IDLE;
            end
         end
         default: state_in = hwq_pkg::ST_IDLE;
      endcase

      // Drop the frame totals on a length write
      if (cfg_clear) begin
         ctot_in = 31'd0;
         stot_in = 47'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hwq_pkg::ST_IDLE;
         valid_ff <= 1'b0;
         ctot_ff  <= 31'd0;
         stot_ff  <= 47'd0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         ctot_ff  <= ctot_in;
         stot_ff  <= stot_in;
      end
   end

   // Hold datapath and output payload
   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      phase_ff  <= phase_in;
      a_ff      <= a_in;
      ip_ff     <= ip_in;
      coef_ff   <= coef_in;
      prod_ff   <= prod_in;
      w_ff      <= w_in;
      cg_ff     <= cg_in;
      pg_ff     <= pg_in;
      o_w_ff    <= o_w_in;
      o_coef_ff <= o_coef_in;
      o_last_ff <= o_last_in;
      o_cg_ff   <= o_cg_in;
      o_pg_ff   <= o_pg_in;
   end
endmodule

// File: hw/rtl/hwq_checker.sv
// Port-level checks on the Hann window unit, bound to its top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module hwq_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [15:0] rsp_windowed_sample,
   input logic [14:0]        rsp_coefficient,
   input logic               rsp_last_of_frame,
   input logic [14:0]        rsp_coherent_gain_q15,
   input logic [29:0]        rsp_power_gain_q30
);
   // Nothing leaves the block right after reset
   `HWQ_ASSERT_ALWAYS(a_no_rsp_after_reset, clock, $past(reset) |-> !rsp_valid)

   // A stalled result beat stays offered
   `HWQ_ASSERT(a_rsp_held, clock, reset, rsp_valid && rsp_stall |=> rsp_valid)

   // Gains only on the frame end
   `HWQ_ASSERT(a_gain_zero, clock, reset,
      rsp_valid && !rsp_last_of_frame |->
         rsp_coherent_gain_q15 == 15'd0 && rsp_power_gain_q30 == 30'd0)

   // A zero coefficient leaves nothing of the sample
   `HWQ_ASSERT(a_zero_coef, clock, reset,
      rsp_valid && rsp_coefficient == 15'd0 |-> rsp_windowed_sample == 16'sd0)
endmodule

bind hann_window_q15_apply_unit hwq_checker u_hwq_checker (
   .clock                 (clock),
   .reset                 (reset),
   .rsp_valid             (rsp_valid),
   .rsp_stall             (rsp_stall),
   .rsp_windowed_sample   (rsp_windowed_sample),
   .rsp_coefficient       (rsp_coefficient),
   .rsp_last_of_frame     (rsp_last_of_frame),
   .rsp_coherent_gain_q15 (rsp_coherent_gain_q15),
   .rsp_power_gain_q30    (rsp_power_gain_q30)
);

// File: tb/sv/tb_hann_window_q15_apply_unit.sv
// Self-checking testbench for hann_window_q15_apply_unit: drives sample beats,
// predicts each windowed result with a local Hann model and compares them.
// Depends on hwq_pkg and the hann_window_q15_apply_unit RTL.
`timescale 1ns / 1ps

module tb_hann_window_q15_apply_unit;

   typedef struct {
      logic signed [15:0] windowed;
      logic [14:0]        coef;
      logic               last;
      logic [14:0]        cgain;
      logic [29:0]        pgain;
   } hann_result_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [15:0] req_sample;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [15:0] rsp_windowed_sample;
   logic [14:0]        rsp_coefficient;
   logic               rsp_last_of_frame;
   logic [14:0]        rsp_coherent_gain_q15;
   logic [29:0]        rsp_power_gain_q30;
   logic               csr_valid;
   logic               csr_ready;
   logic [15:0]        csr_data;

   // Predictor state
   logic [15:0] win_len;
   logic [15:0] frame_pos;
   logic [63:0] coef_sum;
   logic [63:0] square_sum;

   logic signed [15:0] pending_samples[$];
   hann_result_type    expected_results[$];
   int                 send_idle_pct;
   int                 stall_pct;
   int                 error_count;
   int                 result_count;
   int                 frame_ends;

   hann_window_q15_apply_unit i_dut (.*);

   // Hold clock period at 20 ns
   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // Sine over a 256-step circle from the quarter table
   function automatic int circle_sine(input int idx);
      int quad;
      int off;
      int mag;
      quad = (idx >> 6) & 3;
      off = idx & 63;
      if (quad == 1 || quad == 3) off = 64 - off;
      mag = int'(hwq_pkg::quarter_sine(7'(off)));
      return (quad >= 2) ? -mag : mag;
   endfunction

   function automatic int round_away(input longint num, input longint den);
      if (num >= 0) return int'((num + den / 2) / den);
      return -int'((-num + den / 2) / den);
   endfunction

   // Compute the result of one sample and advance the frame
   function automatic hann_result_type hann_predict(input logic signed [15:0] smp);
      hann_result_type r;
      longint unsigned len;
      longint unsigned pos;
      longint unsigned m;
      logic [31:0]     ph;
      int              idx;
      int              a;
      int              b;
      int              cosv;
      int              coef;
      len = (win_len < hwq_pkg::LEN_MIN) ? 3 : win_len;
      pos = frame_pos;
      if (pos >= len) pos = 0;
      m = len - 1 - pos;
      if (pos < m) m = pos;
      ph = 32'((m << 32) / (len - 1));
      ph = ph + hwq_pkg::QUARTER_PHASE;
      idx = ph[31:24];
      a = circle_sine(idx);
      b = circle_sine((idx + 1) & 255);
      cosv = a + round_away(longint'(b - a) * longint'(ph[23:8]), 65536);
      coef = (32768 - cosv) / 2;
      r.windowed = 16'(round_away(longint'(smp) * coef, 32768));
      r.coef = 15'(coef);
      coef_sum += coef;
      square_sum += longint'(coef) * coef;
      r.last = (pos == len - 1);
      if (r.last) begin
         r.cgain = 15'((coef_sum + len / 2) / len);
         r.pgain = 30'((square_sum + len / 2) / len);
         frame_pos = 0;
         coef_sum = 0;
         square_sum = 0;
      end else begin
         r.cgain = '0;
         r.pgain = '0;
         frame_pos = 16'(pos + 1);
      end
      return r;
   endfunction

   // Driver: present queued samples, idling at random; predict on accept
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_sample <= '0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_results.push_back(hann_predict(req_sample));
            void'(pending_samples.pop_front());
         end
         if (!req_valid || !req_stall) begin
            if (req_valid && !req_stall) begin
               // beat just taken: next one comes from the queue head
            end
            if (pending_samples.size() > 0 && !(req_valid && !req_stall
                  && pending_samples.size() == 0)
                  && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_sample <= pending_samples[0];
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each accepted result beat and randomize stall
   always @(posedge clock) begin
      hann_result_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            result_count++;
            if (rsp_last_of_frame) frame_ends++;
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result beat, windowed %0d", $realtime,
                        rsp_windowed_sample);
               error_count++;
            end else begin
               e = expected_results.pop_front();
               if (rsp_windowed_sample !== e.windowed || rsp_coefficient !== e.coef
                   || rsp_last_of_frame !== e.last || rsp_coherent_gain_q15 !== e.cgain
                   || rsp_power_gain_q30 !== e.pgain) begin
                  $display("%0t: mismatch expected w=%0d c=%0d l=%0b cg=%0d pg=%0d",
                           $realtime, e.windowed, e.coef, e.last, e.cgain, e.pgain);
                  $display("%0t:          actual w=%0d c=%0d l=%0b cg=%0d pg=%0d",
                           $realtime, rsp_windowed_sample, rsp_coefficient,
                           rsp_last_of_frame, rsp_coherent_gain_q15, rsp_power_gain_q30);
                  error_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic wait_drained();
      while (pending_samples.size() > 0 || req_valid || expected_results.size() > 0)
         @(posedge clock);
   endtask

   // Write the frame length while idle, with margin for the gain divisions
   task automatic write_length(input logic [15:0] len);
      wait_drained();
      repeat (150) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= len;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      win_len = len;
      frame_pos = 0;
      coef_sum = 0;
      square_sum = 0;
   endtask

   function automatic logic signed [15:0] random_sample();
      case ($urandom_range(7))
         0: return 16'sh7FFF;
         1: return -16'sh8000;
         2: return 16'(signed'($urandom_range(8)) - 4);
         default: return 16'($urandom);
      endcase
   endfunction

   // Queue the given number of random samples
   task automatic queue_samples(input int count);
      for (int k = 0; k < count; k++) pending_samples.push_back(random_sample());
   endtask

   initial begin
      logic [15:0] lens[8];
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_data = '0;
      req_valid = 1'b0;
      req_sample = '0;
      rsp_stall = 1'b0;
      send_idle_pct = 0;
      stall_pct = 0;
      error_count = 0;
      result_count = 0;
      frame_ends = 0;
      win_len = hwq_pkg::LEN_RESET;
      frame_pos = 0;
      coef_sum = 0;
      square_sum = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes at the reset length, then short-length cases
      pending_samples.push_back(16'sh7FFF);
      pending_samples.push_back(-16'sh8000);
      pending_samples.push_back(16'sh0000);
      pending_samples.push_back(-16'sh0001);
      pending_samples.push_back(16'sh0001);
      write_length(16'd0);
      queue_samples(4);
      write_length(16'd2);
      queue_samples(3);
      write_length(16'd1);
      queue_samples(3);
      write_length(16'd3);
      queue_samples(7);
      // Restart mid-frame by a length write
      write_length(16'd5);
      queue_samples(2);

      // Random: phases of sender idling and receiver stalling over several lengths, extremes included
      lens = '{16'd4, 16'd7, 16'd16, 16'd33, 16'd64, 16'd65535, 16'd9, 16'd128};
      for (int ph = 0; ph < 8; ph++) begin
         write_length(ph == 7 ? 16'($urandom_range(3, 200)) : lens[ph]);
         case (ph % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 83; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 83; end
            default: begin send_idle_pct = 30; stall_pct = 30; end
         endcase
         queue_samples(ph == 5 ? 40 : 70);
         if (ph == 3) begin
            // Hold off until everything in flight has come back
            wait_drained();
            queue_samples(10);
         end
      end
      wait_drained();
      repeat (300) @(posedge clock);
      $display("Covered %0d result beats and %0d frame ends over lengths 0..65535",
               result_count, frame_ends);
      $display("with sender idling and receiver stalling in separate and mixed phases.");
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Hard limit on run time
   initial begin
      #400ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
